/* sv/sbg_pkg.sv */
// Shared types, constants and pixel helpers for the scrolling bar graph column writer.
// Depends on nothing; imported by the front, queue, back and top level modules.
`default_nettype none

package sbg_pkg;

  localparam logic [15:0] FILL_PATTERN = 16'hFF00;
  localparam logic [7:0]  GRID_MASK_P1 = 8'h04;
  localparam logic [7:0]  GRID_MASK_P3 = 8'h20;
  localparam logic [1:0]  BLANK_MAX    = 2'd3;

  localparam logic [1:0] REG_FIRST_COLUMN = 2'd0;
  localparam logic [1:0] REG_LAST_COLUMN  = 2'd1;
  localparam logic [1:0] REG_HISTORY_LEN  = 2'd2;

  typedef enum logic [1:0] {
    PH_CUR,
    PH_DLY,
    PH_BLK
  } phase_t;

  typedef struct packed {
    logic [7:0] first_column;
    logic [7:0] last_column;
    logic [6:0] history_len;
  } cfg_t;

  typedef struct packed {
    logic [7:0] cur_col;
    logic [5:0] bar_v;
    logic [5:0] avg_v;
    logic [5:0] old_v;
    logic       dly;
    logic [7:0] sec_col;
    logic       blank;
    logic [7:0] blk_col;
    logic [1:0] blk_w;
  } desc_t;

  // Thermometer fill of one page byte for a bar of height v.
  function automatic logic [7:0] fill_byte(input logic [5:0] v, input logic [2:0] page);
    logic [6:0]  lo;
    logic [6:0]  diff;
    logic [15:0] sh;
    logic [7:0]  res;
    lo   = {1'b0, page, 3'b000};
    diff = {1'b0, v} - lo;
    sh   = FILL_PATTERN >> diff[2:0];
    if ({1'b0, v} >= (lo + 7'd8)) begin
      res = 8'hFF;
    end else if ({1'b0, v} < lo) begin
      res = 8'h00;
    end else begin
      res = sh[7:0];
    end
    return res;
  endfunction

  // Dashed grid on pages 1 and 3: set on odd columns, clear on even ones.
  function automatic logic [7:0] grid_byte(input logic [7:0] b, input logic [2:0] page,
                                           input logic odd);
    logic [7:0] res;
    res = b;
    if (page == 3'd1) begin
      res = odd ? (b | GRID_MASK_P1) : (b & ~GRID_MASK_P1);
    end else if (page == 3'd3) begin
      res = odd ? (b | GRID_MASK_P3) : (b & ~GRID_MASK_P3);
    end
    return res;
  endfunction

  // Average marker: black at av-1..av+1, white at av-2 and av+2.
  function automatic logic [7:0] marker_byte(input logic [7:0] b, input logic [2:0] page,
                                             input logic [5:0] av);
    logic [7:0] res;
    logic [7:0] pix;
    logic [7:0] a;
    res = b;
    a   = {2'b00, av};
    for (int j = 0; j < 8; j++) begin
      pix = {2'b00, page, 3'(j)};
      if (pix == a || pix == a + 8'd1 || pix + 8'd1 == a) begin
        res[7-j] = 1'b0;
      end else if (pix == a + 8'd2 || pix + 8'd2 == a) begin
        res[7-j] = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* sv/scrolling_bar_graph_columns.sv */
// Scrolling bar graph column writer: top level with configuration registers.
// Depends on sbg_pkg, sbg_front, sbg_queue and sbg_back.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one word per value: the current
//   bar height and the average marker position. Each word produces display
//   writes on the result channel (out_valid/out_ready): five page writes of
//   the current bar, then, once the shown count exceeds twice history_len, five
//   page writes of the delayed bar with its marker, then five blank-strip writes
//   ahead of the cursor when the strip lies inside the graph area. out_last_write
//   marks the final write of each word.
//   Throughput: one write per cycle while out_ready is high, driven by the
//   back-end write sequencer. The front accepts a new word each cycle while
//   the two-entry descriptor queue has room, so input and output overlap.
//   When the back end is idle, the first write of a word passes the front
//   stage, the queue, the back-end descriptor register and the output register.
//   Reset (rst_n low, synchronous) clears cursor, ring index, shown count,
//   queue and sequencer, and loads the register defaults; the history ring
//   is not cleared and holds stale data until written.
//   When the receiver stalls, the current write holds on the outputs, the
//   sequencer waits, the queue fills, and in_ready drops. Configuration
//   (cfg_we, cfg_index, cfg_data) is to be written by the user only while idle; the block does not enforce it.
`default_nettype none

module scrolling_bar_graph_columns #(
  parameter int HISTORY_DEPTH = 64,
  parameter int BAR_HEIGHT    = 40
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [5:0] in_bar_value,
  input  wire logic [5:0] in_avg_value,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      out_page_row,
  output logic [7:0]      out_column,
  output logic [1:0]      out_span,
  output logic [7:0]      out_pixels,
  output logic            out_last_write
);
  import sbg_pkg::*;

  cfg_t  cfg_r;
  logic  q_push;
  desc_t q_push_desc;
  logic  q_full;
  logic  q_pop;
  desc_t q_pop_desc;
  logic  q_nonempty;

  // Hold configuration; writes to indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_column <= 8'd0;
      cfg_r.last_column  <= 8'd127;
      cfg_r.history_len  <= 7'd32;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FIRST_COLUMN: cfg_r.first_column <= cfg_data;
        REG_LAST_COLUMN:  cfg_r.last_column  <= cfg_data;
        REG_HISTORY_LEN:  cfg_r.history_len  <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  // Classify each value and keep the scrolling state.
  sbg_front #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_bar_value(in_bar_value),
    .in_avg_value(in_avg_value),
    .q_push      (q_push),
    .q_desc      (q_push_desc),
    .q_full      (q_full)
  );

  // Decouple front and back so each can stall on its own.
  sbg_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_desc(q_push_desc),
    .full     (q_full),
    .pop      (q_pop),
    .pop_desc (q_pop_desc),
    .nonempty (q_nonempty)
  );

  // Emit the page writes, one per cycle while the receiver is ready.
  sbg_back #(
    .BAR_HEIGHT(BAR_HEIGHT)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_nonempty    (q_nonempty),
    .q_desc        (q_pop_desc),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_page_row  (out_page_row),
    .out_column    (out_column),
    .out_span      (out_span),
    .out_pixels    (out_pixels),
    .out_last_write(out_last_write)
  );

endmodule

`default_nettype wire

/* sv/sbg_front.sv */
// Front end: accepts values, tracks cursor, history ring and count, builds write descriptors.
// Depends on sbg_pkg; feeds sbg_queue.
`default_nettype none

module sbg_front #(
  parameter int HISTORY_DEPTH = 64
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire sbg_pkg::cfg_t cfg,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [5:0]    in_bar_value,
  input  wire logic [5:0]    in_avg_value,
  output logic               q_push,
  output sbg_pkg::desc_t     q_desc,
  input  wire logic          q_full
);
  import sbg_pkg::*;

  localparam int RING_AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  logic [5:0]         ring [HISTORY_DEPTH];
  logic [5:0]         old_r;
  logic [7:0]         col_r, col_nxt;
  logic [RING_AW-1:0] idx_r, idx_nxt;
  logic [7:0]         cnt_r, cnt_nxt;
  logic               stage_v_r, stage_v_nxt;
  desc_t              stage_r, stage_nxt;
  logic               accept;
  logic [7:0]         hl2;
  logic [RING_AW:0]   idx_inc;
  logic [9:0]         diff_s;
  logic [9:0]         hl_s;
  logic [7:0]         blk_start;
  logic [7:0]         blk_span;

  assign in_ready = !stage_v_r || !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = stage_v_r && !q_full;
  assign hl2      = {cfg.history_len, 1'b0};

  always_comb begin
    q_desc       = stage_r;
    q_desc.old_v = old_r;
  end

  // Classify the incoming value against the current cursor and count.
  always_comb begin
    diff_s    = {2'b00, col_r} - {2'b00, cfg.first_column};
    hl_s      = {3'b000, cfg.history_len};
    blk_start = col_r + 8'd1;
    blk_span  = cfg.last_column - blk_start;

    stage_nxt         = stage_r;
    stage_nxt.cur_col = col_r;
    stage_nxt.bar_v   = in_bar_value;
    stage_nxt.avg_v   = in_avg_value;
    stage_nxt.old_v   = '0;
    stage_nxt.dly     = cnt_r > hl2;
    if ($signed(hl_s) <= $signed(diff_s)) begin
      stage_nxt.sec_col = col_r - {1'b0, cfg.history_len};
    end else begin
      stage_nxt.sec_col = cfg.last_column - {1'b0, cfg.history_len} + col_r
                          - cfg.first_column;
    end
    stage_nxt.blank   = blk_start <= cfg.last_column;
    stage_nxt.blk_col = blk_start;
    stage_nxt.blk_w   = (blk_span >= 8'd2) ? BLANK_MAX : (blk_span[1:0] + 2'd1);

    stage_v_nxt = accept ? 1'b1 : (q_push ? 1'b0 : stage_v_r);

    // Advance cursor, ring index (unless history_len is 0) and saturating count on accept.
    col_nxt = col_r;
    idx_nxt = idx_r;
    cnt_nxt = cnt_r;
    idx_inc = {1'b0, idx_r} + {{RING_AW{1'b0}}, 1'b1};
    if (accept) begin
      col_nxt = (blk_start > cfg.last_column) ? cfg.first_column : blk_start;
      if (cfg.history_len != 7'd0) begin
        if (int'(idx_inc) >= HISTORY_DEPTH || int'(idx_inc) == int'(cfg.history_len)) begin
          idx_nxt = '0;
        end else begin
          idx_nxt = idx_inc[RING_AW-1:0];
        end
      end
      if (cnt_r <= hl2) begin
        cnt_nxt = cnt_r + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      idx_r     <= '0;
      cnt_r     <= '0;
      stage_v_r <= 1'b0;
    end else begin
      col_r     <= col_nxt;
      idx_r     <= idx_nxt;
      cnt_r     <= cnt_nxt;
      stage_v_r <= stage_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_r <= stage_nxt;
    end
  end

  // Read the old entry before overwriting it with the new value.
  always_ff @(posedge clk) begin
    if (accept) begin
      old_r <= ring[idx_r];
      if (cfg.history_len != 7'd0) begin
        ring[idx_r] <= in_bar_value;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/sbg_queue.sv */
// Two-entry descriptor queue between front and back ends.
// Depends on sbg_pkg for the descriptor type.
`default_nettype none

module sbg_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire sbg_pkg::desc_t push_desc,
  output logic                full,
  input  wire logic           pop,
  output sbg_pkg::desc_t      pop_desc,
  output logic                nonempty
);
  import sbg_pkg::*;

  desc_t      entries_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign full     = count_r == 2'd2;
  assign nonempty = count_r != 2'd0;
  assign pop_desc = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_desc;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full || pop)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> nonempty)
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n) count_r != 2'd3)
    else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

/* sv/sbg_back.sv */
// Back end: walks each descriptor through its current, delayed and blank writes.
// Depends on sbg_pkg; drains sbg_queue and drives the result channel register.
`default_nettype none

module sbg_back #(
  parameter int BAR_HEIGHT = 40
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_nonempty,
  input  wire sbg_pkg::desc_t q_desc,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [2:0]          out_page_row,
  output logic [7:0]          out_column,
  output logic [1:0]          out_span,
  output logic [7:0]          out_pixels,
  output logic                out_last_write
);
  import sbg_pkg::*;

  localparam int         PAGES    = BAR_HEIGHT / 8;
  localparam logic [2:0] ROW_LAST = 3'(PAGES - 1);

  desc_t      desc_r;
  phase_t     phase_r, phase_nxt;
  logic [2:0] row_r, row_nxt;
  logic       busy_r, busy_nxt;
  logic       emit;
  logic       last;
  logic [2:0] page;
  logic [7:0] pix;
  logic [7:0] col;
  logic [1:0] width;
  logic       out_valid_r;

  assign out_valid = out_valid_r;
  assign emit      = busy_r && (!out_valid_r || out_ready);
  assign page      = ROW_LAST - row_r;
  assign q_pop     = q_nonempty && (!busy_r || (emit && last));

  always_comb begin
    pix   = 8'h00;
    col   = desc_r.blk_col;
    width = 2'd1;
    last  = 1'b0;
    unique case (phase_r)
      PH_CUR: begin
        pix  = grid_byte(fill_byte(desc_r.bar_v, page), page, desc_r.cur_col[0]);
        col  = desc_r.cur_col;
        last = (row_r == ROW_LAST) && !desc_r.dly;
      end
      PH_DLY: begin
        pix  = grid_byte(marker_byte(fill_byte(desc_r.old_v, page), page, desc_r.avg_v),
                         page, desc_r.sec_col[0]);
        col  = desc_r.sec_col;
        last = (row_r == ROW_LAST) && !desc_r.blank;
      end
      PH_BLK: begin
        width = desc_r.blk_w;
        last  = row_r == ROW_LAST;
      end
      default: begin
        last = 1'b1;
      end
    endcase
  end

  // Step row by row; move to the next phase at the last page, or go idle after the final write.
  always_comb begin
    phase_nxt = phase_r;
    row_nxt   = row_r;
    busy_nxt  = busy_r;
    if (q_pop) begin
      phase_nxt = PH_CUR;
      row_nxt   = 3'd0;
      busy_nxt  = 1'b1;
    end else if (emit) begin
      if (last) begin
        busy_nxt = 1'b0;
      end else if (row_r == ROW_LAST) begin
        row_nxt   = 3'd0;
        phase_nxt = (phase_r == PH_CUR) ? PH_DLY : PH_BLK;
      end else begin
        row_nxt = row_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_CUR;
      row_r       <= 3'd0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      row_r   <= row_nxt;
      busy_r  <= busy_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      desc_r <= q_desc;
    end
    if (emit) begin
      out_page_row   <= row_r;
      out_column     <= col;
      out_span       <= width;
      out_pixels     <= pix;
      out_last_write <= last;
    end
  end

`ifndef SYNTHESIS
  a_dly_phase: assert property (@(posedge clk) disable iff (!rst_n)
      busy_r && phase_r == PH_DLY |-> desc_r.dly)
    else $error("delayed write without delayed bar");
  a_blk_phase: assert property (@(posedge clk) disable iff (!rst_n)
      busy_r && phase_r == PH_BLK |-> desc_r.blank && desc_r.dly)
    else $error("blank write without blank strip");
  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid_r && out_last_write |-> out_page_row == ROW_LAST)
    else $error("last write not on final page row");
  a_busy_pop: assert property (@(posedge clk) disable iff (!rst_n)
      busy_r && emit && !last |-> !q_pop)
    else $error("descriptor reloaded mid sequence");
`endif

endmodule

`default_nettype wire
